[sv/fsba_pkg.sv]
// Shared constants, codes and control structs for the fit-strategy block allocator.
// No dependencies; every file of the block but fsba_ram imports this package.
`timescale 1ns / 1ps

package fsba_pkg;

  // Table geometry.
  localparam int NUM_BLOCKS = 64;
  localparam int SIZE_BITS  = 32;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);

  // Field widths of the stream items and registers.
  localparam int BIDX_W      = 6;
  localparam int CNT_W       = 7;
  localparam int STRAT_W     = 2;
  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;

  // Bit positions inside the input tdata.
  localparam int BIDX_LSB  = 0;
  localparam int BSIZE_LSB = BIDX_LSB + BIDX_W;
  localparam int REQ_LSB   = BSIZE_LSB + SIZE_BITS;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STRATEGY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd1;

  // Placement rules. The unused code behaves as first fit.
  localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd0;
  localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd1;
  localparam logic [STRAT_W-1:0] STRAT_WORST = 2'd2;
  localparam logic [STRAT_W-1:0] STRAT_SPARE = 2'd3;

  // Operation codes carried in the input tuser.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_ALLOC = 1'b1;

  // Controller to datapath.
  typedef struct packed {
    logic load;    // write an input item's size into the table
    logic start;   // latch a request and clear the search
    logic rd_en;   // read the next table entry
    logic finish;  // charge the chosen block and load the result register
  } fsba_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic limit_zero;  // no block is scanned for this request
    logic last_rd;     // the read being issued is the last one
    logic out_free;    // the result register can take a new item
  } fsba_sts_t;

endpackage

[sv/fsba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fsba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/fsba_ctrl.sv]
// Controller state machine of the fit-strategy block allocator.
// Depends on fsba_pkg for the command and status structs and the operation codes.
`timescale 1ns / 1ps

module fsba_ctrl import fsba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  logic      s_tuser,   // func
  input  fsba_sts_t sts,
  output fsba_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_READ   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == FUNC_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_READ: begin
        if (sts.limit_zero) begin
          state_next = ST_FINISH;
        end else begin
          cmd.rd_en = 1'b1;
          if (sts.last_rd) begin
            state_next = ST_DRAIN;
          end
        end
      end
      // The last entry read is compared in this cycle.
      ST_DRAIN: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/fsba_datapath.sv]
// Datapath of the fit-strategy block allocator: registers, free-size table,
// scan compare, write-back and result register. Depends on fsba_pkg and fsba_ram.
`timescale 1ns / 1ps

module fsba_datapath import fsba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  input  fsba_cmd_t             cmd,
  output fsba_sts_t             sts
);

  logic [STRAT_W-1:0]   strategy;
  logic [CNT_W-1:0]     block_count;
  logic [CNT_W-1:0]     limit;
  logic [CNT_W-1:0]     limit_in;
  logic [SIZE_BITS-1:0] req;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     cmp_addr;
  logic                 rd_vld;
  logic                 found;
  logic [IDX_W-1:0]     best_idx;
  logic [SIZE_BITS-1:0] best_sz;
  logic [SIZE_BITS-1:0] rdata;
  logic                 fits;
  logic                 take;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [SIZE_BITS-1:0] ram_wdata;

  // A block count above the table size scans the whole table.
  assign limit_in = (block_count > CNT_W'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      strategy    <= STRAT_FIRST;
      block_count <= CNT_W'(NUM_BLOCKS);
      rd_vld      <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STRATEGY:    strategy    <= cfg_data[STRAT_W-1:0];
          REG_BLOCK_COUNT: block_count <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      rd_vld <= cmd.rd_en;
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Compare stage: the entry read last cycle against the request and the best so far.
  assign fits = (rdata >= req);
  always_comb begin
    take = 1'b0;
    if (rd_vld && fits) begin
      if (!found) begin
        take = 1'b1;
      end else if (strategy == STRAT_BEST) begin
        take = (rdata < best_sz);
      end else if (strategy == STRAT_WORST) begin
        take = (rdata > best_sz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req      <= s_tdata[REQ_LSB +: SIZE_BITS];
      limit    <= limit_in;
      rd_addr  <= '0;
      found    <= 1'b0;
      best_idx <= '0;
    end else begin
      if (cmd.rd_en) begin
        rd_addr  <= rd_addr + 1'b1;
        cmp_addr <= rd_addr;
      end
      if (take) begin
        found    <= 1'b1;
        best_idx <= cmp_addr;
        best_sz  <= rdata;
      end
    end
    if (cmd.finish) begin
      m_tuser <= found;
      m_tdata <= OUT_DATA_W'(best_idx);
    end
  end

  assign sts.limit_zero = (limit == '0);
  assign sts.last_rd    = ({1'b0, rd_addr} == (limit - 1'b1));
  assign sts.out_free   = !m_tvalid || m_tready;

  // One write port shared by loads and by the charge of the chosen block.
  assign ram_we    = cmd.load || (cmd.finish && found);
  assign ram_waddr = cmd.load ? s_tdata[BIDX_LSB +: IDX_W] : best_idx;
  assign ram_wdata = cmd.load ? s_tdata[BSIZE_LSB +: SIZE_BITS] : (best_sz - req);

  fsba_ram #(
    .WIDTH(SIZE_BITS),
    .DEPTH(NUM_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

endmodule

[sv/fit_strategy_block_allocator.sv]
// Top level of the fit-strategy block allocator: controller plus datapath.
// Depends on fsba_pkg, fsba_ctrl, fsba_datapath and fsba_ram.
//
//   channel   direction  handshake             payload
//   s_*       in         s_tvalid / s_tready   tuser: func; tdata: index, size, request
//   m_*       out        m_tvalid / m_tready   tuser: granted; tdata: chosen_block
//   cfg_*     in         cfg_we                cfg_index, cfg_data
//
// A load is written into the table as it is accepted. An allocation scans L entries,
// L = min(block_count, 64): one table read per cycle through the single read port,
// then one compare, then the write-back.
// Reset restores the registers and handshake; the table stays undefined until loaded.
// A result waits in its output register; the next item is taken meanwhile and its
// scan runs, but it is not finished until the register is free.
`timescale 1ns / 1ps

module fit_strategy_block_allocator import fsba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // block_index[5:0], block_size[37:6],
                                           // request_size[69:38], zero pad
  input  logic                  s_tuser,   // func
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // chosen_block[5:0], zero pad
  output logic                  m_tuser    // granted
);

  fsba_cmd_t cmd;
  fsba_sts_t sts;

  fsba_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .sts     (sts),
    .cmd     (cmd)
  );

  fsba_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

  // A started allocation closes the input until it has finished.
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> !s_tready)
    else $error("input accepted during an allocation");

  // Finishing an allocation always presents a result in the next cycle.
  a_finish_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished allocation produced no result");

  // A refused allocation reports block zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("failed allocation with nonzero block index");

  // Table reads never overlap a table write.
  a_rd_no_wr: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (!cmd.load && !cmd.finish))
    else $error("table read and write in the same cycle");

endmodule

[tb/fit_strategy_block_allocator_test.sv]
// Self-checking testbench for fit_strategy_block_allocator: loads free sizes, issues
// allocations under every placement rule and several block counts, and checks each result.
// Depends on fsba_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module fit_strategy_block_allocator_test import fsba_pkg::*; ();

  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [SIZE_BITS-1:0] MAX_SIZE = '1;

  typedef struct packed {
    logic              granted;
    logic [BIDX_W-1:0] block;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // block_index, block_size, request_size, zero pad
  logic                  s_tuser = 1'b0; // func
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // chosen_block, zero pad
  logic                  m_tuser;        // granted

  // Shadow of the allocator state.
  logic [SIZE_BITS-1:0] free_sz [NUM_BLOCKS];
  bit                   loaded [NUM_BLOCKS];
  logic [STRAT_W-1:0]   strategy;
  logic [CNT_W-1:0]     block_count;

  grant_t pending_grants[$];
  grant_t want;
  int     mismatches = 0;
  int     stall_left = 0;
  int     quiet_cycles = 0;
  bit     idle_on = 1'b1;

  fit_strategy_block_allocator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int scan_limit();
    return (block_count > NUM_BLOCKS) ? NUM_BLOCKS : int'(block_count);
  endfunction

  // Searches the shadow table for the block the current rule picks and charges it.
  function automatic grant_t allocate_predicted(logic [SIZE_BITS-1:0] req);
    grant_t r;
    int     lim;
    int     j;
    int     pick;
    bit     found;
    lim = scan_limit();
    pick = 0;
    found = 1'b0;
    for (j = 0; j < lim; j++) begin
      if (free_sz[j] < req) continue;
      if (!found) begin
        found = 1'b1;
        pick = j;
        if (strategy != STRAT_BEST && strategy != STRAT_WORST) break;
      end else if (strategy == STRAT_BEST && free_sz[j] < free_sz[pick]) begin
        pick = j;
      end else if (strategy == STRAT_WORST && free_sz[j] > free_sz[pick]) begin
        pick = j;
      end
    end
    r = '0;
    if (found) begin
      free_sz[pick] = free_sz[pick] - req;
      r.granted = 1'b1;
      r.block = pick[BIDX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [SIZE_BITS-1:0] rand_size();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return MAX_SIZE;
      2, 3: return $urandom;
      default: return $urandom_range(0, 4096);
    endcase
  endfunction

  function automatic logic [SIZE_BITS-1:0] rand_request();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return MAX_SIZE;
      2: return $urandom;
      default: return $urandom_range(1, 1500);
    endcase
  endfunction

  // Sends one item; returns at the edge where it is accepted with tvalid still high.
  task automatic send_item(logic func, logic [BIDX_W-1:0] idx,
                           logic [SIZE_BITS-1:0] bsize, logic [SIZE_BITS-1:0] req);
    logic [IN_DATA_W-1:0] word;
    int                   gap;
    word = '0;
    word[BIDX_LSB +: BIDX_W] = idx;
    word[BSIZE_LSB +: SIZE_BITS] = bsize;
    word[REQ_LSB +: SIZE_BITS] = req;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= word;
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_LOAD) begin
      free_sz[idx] = bsize;
      loaded[idx] = 1'b1;
    end else begin
      pending_grants.push_back(allocate_predicted(req));
    end
  endtask

  task automatic send_load(int idx, logic [SIZE_BITS-1:0] bsize);
    send_item(FUNC_LOAD, idx[BIDX_W-1:0], bsize, $urandom);
  endtask

  task automatic send_alloc(logic [SIZE_BITS-1:0] req);
    send_item(FUNC_ALLOC, BIDX_W'($urandom), $urandom, req);
  endtask

  // Stops sending, waits for every expected result, then lets a trailing load finish.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers; only called while the block is idle.
  task automatic configure(logic [STRAT_W-1:0] strat, logic [CNT_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= REG_STRATEGY;
    cfg_data <= CFG_DATA_W'(strat);
    @(posedge clk);
    strategy = strat;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data <= CFG_DATA_W'(count);
    @(posedge clk);
    block_count = count;
    cfg_we <= 1'b0;
  endtask

  // Every scanned entry must hold a loaded size before an allocation reads it.
  task automatic load_missing();
    int j;
    for (j = 0; j < scan_limit(); j++)
      if (!loaded[j]) send_load(j, rand_size());
  endtask

  task automatic test_placement_rules();
    configure(STRAT_FIRST, 4);
    send_load(0, 100);
    send_load(1, MAX_SIZE);
    send_load(2, 50);
    send_load(3, 100);
    send_alloc(60);          // first fit: block 0, leaves 40
    send_alloc(MAX_SIZE);    // only block 1 fits the largest request
    send_alloc(0);           // a zero request fits block 0 and charges nothing
    settle();
    configure(STRAT_BEST, 4);
    send_alloc(45);          // block 2 is the tightest fit
    send_load(2, 70);
    send_load(3, 70);
    send_alloc(70);          // equal sizes go to the lower index
    send_alloc(71);          // nothing fits
    settle();
    configure(STRAT_WORST, 4);
    send_load(0, 500);
    send_load(3, 500);
    send_alloc(10);          // tie between blocks 0 and 3
    send_alloc(1000);
    settle();
    configure(STRAT_SPARE, 4);   // the unused code behaves as first fit
    send_alloc(1);
    settle();
  endtask

  task automatic test_block_count_edges();
    configure(STRAT_FIRST, 0);
    send_alloc(0);           // no block is scanned, so even a zero request fails
    send_alloc(5);
    settle();
    configure(STRAT_BEST, 1);
    send_load(63, 0);
    send_alloc(0);
    settle();
    configure(STRAT_WORST, 7'h7F);   // scans all blocks
    load_missing();
    send_alloc(1);
    send_alloc(MAX_SIZE);
    settle();
  endtask

  task automatic run_phase(int n_items);
    int k;
    int lim;
    lim = scan_limit();
    load_missing();
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2 && $urandom_range(0, 2) == 0) settle();
      if ($urandom_range(0, 99) < 35) begin
        if (lim > 0 && $urandom_range(0, 4) != 0)
          send_load($urandom_range(0, lim - 1), rand_size());
        else
          send_load($urandom_range(0, NUM_BLOCKS - 1), rand_size());
      end else begin
        send_alloc(rand_request());
      end
    end
    settle();
  endtask

  task automatic test_random_phases();
    int               i;
    logic [CNT_W-1:0] count;
    for (i = 0; i < 10; i++) begin
      case (i)
        0: count = CNT_W'(64);
        1: count = CNT_W'(1);
        2: count = CNT_W'(0);
        3: count = CNT_W'($urandom_range(65, 127));
        4: count = CNT_W'(64);
        default: count = CNT_W'($urandom_range(2, 20));
      endcase
      idle_on = ($urandom_range(0, 3) != 0);
      configure(STRAT_W'(i % 4), count);
      run_phase(34);
    end
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    configure(STRAT_BEST, 64);
    run_phase(40);
  endtask

  // Result checker.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_grants.size() == 0) begin
        $display("%0t: unexpected result granted=%0b chosen_block=%0d",
                 $time, m_tuser, m_tdata[BIDX_W-1:0]);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (m_tuser !== want.granted) begin
          $display("%0t: granted expected %0b actual %0b", $time, want.granted, m_tuser);
          mismatches++;
        end
        if (m_tdata[BIDX_W-1:0] !== want.block) begin
          $display("%0t: chosen_block expected %0d actual %0d",
                   $time, want.block, m_tdata[BIDX_W-1:0]);
          mismatches++;
        end
      end
    end
  end

  // Receiver stalls in random bursts, started only while idle_on is set.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    strategy = STRAT_FIRST;
    block_count = 7'd64;
    foreach (loaded[j]) begin
      loaded[j] = 1'b0;
      free_sz[j] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_placement_rules();
    test_block_count_edges();
    test_random_phases();
    test_quiet_tail();
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
